/* hw/rtl/setr_pkg.sv */
`default_nettype none

package setr_pkg;

	// Field widths fixed by the stream format.
	localparam int SAMPLE_W   = 16;
	localparam int ENERGY_W   = 32;
	localparam int SUM_W      = 41;
	localparam int IDX_W      = 32;
	localparam int WLEN_W     = 10;
	localparam int FADE_W     = 20;
	localparam int CH_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 41;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ENERGY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_INTRO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_OUTRO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [WLEN_W-1:0] RST_WINDOW_LEN    = 10'd480;
	localparam logic [SUM_W-1:0]  RST_MIN_ENERGY    = 41'd322102887;
	localparam logic [FADE_W-1:0] RST_FADE_LEN      = 20'd4800;
	localparam logic [CH_W-1:0]   RST_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic [WLEN_W-1:0] window_len;
		logic [SUM_W-1:0]  min_energy;
		logic [FADE_W-1:0] fade_len;
		logic              clean_intro;
		logic              clean_outro;
		logic [CH_W-1:0]   channel_count;
	} cfg_t;

	// Word passed from the ring stage to the detection stage.
	typedef struct packed {
		logic                    last;
		logic [IDX_W-1:0]        idx;
		logic signed [ENERGY_W:0] delta;
	} mid_t;

endpackage

`default_nettype wire

/* hw/rtl/setr_frame_if.sv */
`default_nettype none

interface setr_frame_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] sample_left;
	logic signed [15:0] sample_right;
	logic        last_frame;

	modport source(output valid, output sample_left, output sample_right, output last_frame,
		input ready);
	modport sink(input valid, input sample_left, input sample_right, input last_frame,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/setr_result_if.sv */
`default_nettype none

interface setr_result_if;
	logic        valid;
	logic        ready;
	logic        active;
	logic        done_res;
	logic        found;
	logic [31:0] trim_start;
	logic [31:0] trim_end;
	logic [31:0] frame_count;

	modport source(output valid, output active, output done_res, output found,
		output trim_start, output trim_end, output frame_count, input ready);
	modport sink(input valid, input active, input done_res, input found,
		input trim_start, input trim_end, input frame_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/setr_ring_ram.sv */
`default_nettype none

module setr_ring_ram #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write and one registered read per cycle; a read of the entry being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/setr_front.sv */
`default_nettype none

module setr_front #(
	parameter int WINDOW_MAX   = 512,
	parameter int MAX_CHANNELS = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  setr_pkg::cfg_t cfg,
	setr_frame_if.sink     frames,
	output logic           mid_valid,
	output setr_pkg::mid_t mid,
	input  logic           mid_ready
);

	localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int EW    = setr_pkg::ENERGY_W;
	localparam bit STEREO_OK = (MAX_CHANNELS > 1);

	function automatic logic [EW-1:0] square16(input logic [15:0] raw);
		logic [15:0] mag;
		mag = raw[15] ? (16'd0 - raw) : raw;
		return {16'd0, mag} * {16'd0, mag};
	endfunction

	// Stream position state, updated as each word is accepted.
	logic [POS_W-1:0]           pos_q;
	logic [LEN_W-1:0]           fill_q;
	logic [setr_pkg::IDX_W-1:0] idx_q;

	// Stage 1: squares captured, ring entry being read.
	logic                       v1_s1;
	logic [EW-1:0]              sq_l_s1;
	logic [EW-1:0]              sq_r_s1;
	logic [POS_W-1:0]           pos_s1;
	logic                       hit_s1;
	logic                       fwd_s1;
	logic [EW-1:0]              fwd_val_s1;
	logic                       last_s1;
	logic [setr_pkg::IDX_W-1:0] idx_s1;

	// Stage 2: energy change handed to the detection stage.
	logic                       v2_s2;
	setr_pkg::mid_t             mid_s2;

	logic [LEN_W-1:0] len;
	logic [POS_W-1:0] pos_eff;
	logic [LEN_W:0]   pos_inc;
	logic [POS_W-1:0] pos_next;
	logic             acc;
	logic             en1;
	logic             en2;
	logic             adv1;
	logic             stereo;
	logic [EW-1:0]    energy_s1;
	logic [EW-1:0]    old_val;
	logic [EW-1:0]    rdata;
	logic signed [EW:0] delta;

	// Effective window length: zero counts as one, capped at the ring depth.
	always_comb begin
		if (cfg.window_len == '0) begin
			len = LEN_W'(1);
		end else if (32'(cfg.window_len) > 32'(WINDOW_MAX)) begin
			len = LEN_W'(WINDOW_MAX);
		end else begin
			len = LEN_W'(cfg.window_len);
		end
	end

	// A position left beyond a shortened window wraps to zero before use.
	assign pos_eff  = (LEN_W'(pos_q) >= len) ? '0 : pos_q;
	assign pos_inc  = {1'b0, LEN_W'(pos_eff)} + (LEN_W + 1)'(1);
	assign pos_next = (pos_inc >= {1'b0, len}) ? '0 : pos_inc[POS_W-1:0];

	// Handshake chain; each stage moves when the next one is free or moving.
	assign en2          = !v2_s2 || mid_ready;
	assign en1          = !v1_s1 || en2;
	assign adv1         = v1_s1 && en2;
	assign frames.ready = en1;
	assign acc          = frames.valid && en1;
	assign stereo       = STEREO_OK && (cfg.channel_count != 2'd1);

	// Positions are written in order from zero, so every written entry lies
	// below the fill count and every other entry still reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			idx_q  <= '0;
		end else if (acc) begin
			if (frames.last_frame) begin
				pos_q  <= '0;
				fill_q <= '0;
				idx_q  <= '0;
			end else begin
				pos_q <= pos_next;
				if (LEN_W'(pos_eff) >= fill_q) begin
					fill_q <= pos_inc[LEN_W-1:0];
				end
				if (idx_q != setr_pkg::IDX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= frames.valid;
		end
	end

	// Stage 1 payload; the word ahead forwards its energy when it writes the
	// entry read here on the same edge.
	always_ff @(posedge clk) begin
		if (acc) begin
			sq_l_s1    <= square16(frames.sample_left);
			sq_r_s1    <= stereo ? square16(frames.sample_right) : '0;
			pos_s1     <= pos_eff;
			hit_s1     <= LEN_W'(pos_eff) < fill_q;
			fwd_s1     <= adv1 && !last_s1 && (pos_s1 == pos_eff);
			fwd_val_s1 <= energy_s1;
			last_s1    <= frames.last_frame;
			idx_s1     <= idx_q;
		end
	end

	setr_ring_ram #(
		.DEPTH  (WINDOW_MAX),
		.ADDR_W (POS_W),
		.DATA_W (EW)
	) u_ram (
		.clk   (clk),
		.we    (adv1),
		.waddr (pos_s1),
		.wdata (energy_s1),
		.re    (acc),
		.raddr (pos_eff),
		.rdata (rdata)
	);

	// Frame energy, the energy it replaces, and their difference.
	assign energy_s1 = sq_l_s1 + sq_r_s1;
	assign old_val   = fwd_s1 ? fwd_val_s1 : (hit_s1 ? rdata : '0);
	assign delta     = $signed({1'b0, energy_s1}) - $signed({1'b0, old_val});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mid_s2.last  <= last_s1;
			mid_s2.idx   <= idx_s1;
			mid_s2.delta <= delta;
		end
	end

	assign mid_valid = v2_s2;
	assign mid       = mid_s2;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frames.last_frame |=> fill_q == '0 && idx_q == '0 && pos_q == '0)
		else $error("stream state not cleared after the last frame");
	a_fill_covers: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !frames.last_frame |=> LEN_W'(pos_s1) < fill_q)
		else $error("fill count does not cover the entry just taken");
	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc && v1_s1 && !en2 |-> 1'b0)
		else $error("word accepted while stage 1 is stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/setr_tail.sv */
`default_nettype none

module setr_tail (
	input  logic           clk,
	input  logic           arst_n,
	input  setr_pkg::cfg_t cfg,
	input  logic           mid_valid,
	input  setr_pkg::mid_t mid,
	output logic           mid_ready,
	setr_result_if.source  results
);

	localparam int IW = setr_pkg::IDX_W;
	localparam int SW = setr_pkg::SUM_W;

	function automatic logic [IW-1:0] sat_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
		return (a <= b) ? '0 : a - b;
	endfunction

	// Running window sum and stream activity record.
	logic [SW-1:0] sum_q;
	logic          seen_q;
	logic [IW-1:0] first_q;
	logic [IW-1:0] lastact_q;

	// Stage 3: updated window sum.
	logic          v3_s3;
	logic [SW-1:0] sum_s3;
	logic          last_s3;
	logic [IW-1:0] idx_s3;

	// Stage 4: activity decision and stream summary.
	logic          v4_s4;
	logic          act_s4;
	logic          last_s4;
	logic          found_s4;
	logic [IW-1:0] first_s4;
	logic [IW-1:0] lastact_s4;
	logic [IW-1:0] idx_s4;

	// Output register.
	logic          out_valid_q;
	logic          active_q;
	logic          done_q;
	logic          found_q;
	logic [IW-1:0] trim_start_q;
	logic [IW-1:0] trim_end_q;
	logic [IW-1:0] frame_count_q;

	logic              en3;
	logic              en4;
	logic              en_out;
	logic signed [SW:0] sum_ext;
	logic [SW-1:0]     sum_new;
	logic              act;
	logic [IW-1:0]     first_next;
	logic [IW-1:0]     lastact_next;
	logic [IW-1:0]     fc;
	logic [IW-1:0]     start_val;
	logic [IW-1:0]     end_val;
	logic [setr_pkg::FADE_W:0] end_back;

	assign en_out    = !out_valid_q || results.ready;
	assign en4       = !v4_s4 || en_out;
	assign en3       = !v3_s3 || en4;
	assign mid_ready = en3;

	// Window sum update, held at zero should it ever go negative.
	assign sum_ext = $signed({1'b0, sum_q}) + (SW + 1)'(mid.delta);
	assign sum_new = sum_ext[SW] ? '0 : sum_ext[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v3_s3 <= 1'b0;
		end else begin
			if (en3) begin
				v3_s3 <= mid_valid;
			end
			if (mid_valid && en3) begin
				sum_q <= mid.last ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_valid && en3) begin
			sum_s3  <= sum_new;
			last_s3 <= mid.last;
			idx_s3  <= mid.idx;
		end
	end

	// Threshold compare and first/last active frame tracking.
	assign act          = sum_s3 >= cfg.min_energy;
	assign first_next   = (act && !seen_q) ? idx_s3 : first_q;
	assign lastact_next = act ? idx_s3 : lastact_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			first_q   <= '0;
			lastact_q <= '0;
			v4_s4     <= 1'b0;
		end else begin
			if (en4) begin
				v4_s4 <= v3_s3;
			end
			if (v3_s3 && en4) begin
				if (last_s3) begin
					seen_q    <= 1'b0;
					first_q   <= '0;
					lastact_q <= '0;
				end else begin
					seen_q    <= seen_q || act;
					first_q   <= first_next;
					lastact_q <= lastact_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v3_s3 && en4) begin
			act_s4     <= act;
			last_s4    <= last_s3;
			found_s4   <= seen_q || act;
			first_s4   <= first_next;
			lastact_s4 <= lastact_next;
			idx_s4     <= idx_s3;
		end
	end

	// Trim points; pulling the end back twice is one subtraction of twice
	// the fade length.
	assign fc        = (idx_s4 == setr_pkg::IDX_MAX) ? idx_s4 : idx_s4 + 1'b1;
	assign end_back  = (cfg.clean_intro && !cfg.clean_outro) ?
		{cfg.fade_len, 1'b0} : {1'b0, cfg.fade_len};
	assign start_val = cfg.clean_intro ? sat_sub(first_s4, IW'(cfg.fade_len)) : '0;
	assign end_val   = sat_sub(lastact_s4, IW'(end_back));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v4_s4 && en_out) begin
			active_q      <= act_s4;
			done_q        <= last_s4;
			found_q       <= last_s4 && found_s4;
			trim_start_q  <= (last_s4 && found_s4) ? start_val : '0;
			trim_end_q    <= (last_s4 && found_s4) ? end_val : '0;
			frame_count_q <= last_s4 ? fc : '0;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.active      = active_q;
	assign results.done_res    = done_q;
	assign results.found       = found_q;
	assign results.trim_start  = trim_start_q;
	assign results.trim_end    = trim_end_q;
	assign results.frame_count = frame_count_q;

`ifndef SYNTHESIS
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid && en3 && mid.last |=> sum_q == '0)
		else $error("window sum not cleared after the last frame");
	a_idle_record: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> first_q == '0 && lastact_q == '0)
		else $error("activity record set without any active frame");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> first_q <= lastact_q)
		else $error("first active frame after last active frame");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sliding_energy_silence_trim_core.sv */
`default_nettype none

// Silence trimmer for 16-bit PCM frames of one or two channels. Each accepted
// word yields one result word: active tells whether the sum of the frame
// energies over the last window_len frames reaches min_energy, and on the
// frame marked last the word also carries found, the trim start and end
// pulled back by fade_len (saturating at zero; the start is zero without
// clean_intro, and the end goes back twice fade_len with clean_intro and no
// clean_outro) and the frame count, after which the stream state starts
// fresh. One frame is taken every clock cycle unless the result side stalls;
// that rate is set by the ring of frame energies, a single memory that gives
// one read and one write per cycle, with the energy of the frame just ahead
// forwarded when both touch the same entry. The ring needs no clearing pass:
// a fill count marks the entries written in the current stream and the rest
// read as zero. Configuration is written by the user through wr_en, wr_index
// and wr_data while no frame is in flight; the block does not enforce this.
module sliding_energy_silence_trim_core #(
	parameter int WINDOW_MAX   = 512,
	parameter int MAX_CHANNELS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [setr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [setr_pkg::CFG_DATA_W-1:0]   wr_data,
	setr_frame_if.sink                        frames,
	setr_result_if.source                     results
);

	setr_pkg::cfg_t cfg_q;
	logic           mid_valid;
	logic           mid_ready;
	setr_pkg::mid_t mid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len    <= setr_pkg::RST_WINDOW_LEN;
			cfg_q.min_energy    <= setr_pkg::RST_MIN_ENERGY;
			cfg_q.fade_len      <= setr_pkg::RST_FADE_LEN;
			cfg_q.clean_intro   <= 1'b1;
			cfg_q.clean_outro   <= 1'b1;
			cfg_q.channel_count <= setr_pkg::RST_CHANNEL_COUNT;
		end else if (wr_en) begin
			case (wr_index)
				setr_pkg::REG_WINDOW_LEN: begin
					cfg_q.window_len <= wr_data[setr_pkg::WLEN_W-1:0];
				end
				setr_pkg::REG_MIN_ENERGY: begin
					cfg_q.min_energy <= wr_data[setr_pkg::SUM_W-1:0];
				end
				setr_pkg::REG_FADE_LEN: begin
					cfg_q.fade_len <= wr_data[setr_pkg::FADE_W-1:0];
				end
				setr_pkg::REG_CLEAN_INTRO: begin
					cfg_q.clean_intro <= wr_data[0];
				end
				setr_pkg::REG_CLEAN_OUTRO: begin
					cfg_q.clean_outro <= wr_data[0];
				end
				setr_pkg::REG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= wr_data[setr_pkg::CH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	setr_front #(
		.WINDOW_MAX   (WINDOW_MAX),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.frames    (frames),
		.mid_valid (mid_valid),
		.mid       (mid),
		.mid_ready (mid_ready)
	);

	setr_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_valid (mid_valid),
		.mid       (mid),
		.mid_ready (mid_ready),
		.results   (results)
	);

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import setr_pkg::*;

	localparam int WIN_MAX     = 512;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
	} frame_t;

	typedef struct packed {
		logic             active;
		logic             done_res;
		logic             found;
		logic [IDX_W-1:0] trim_start;
		logic [IDX_W-1:0] trim_end;
		logic [IDX_W-1:0] frame_count;
	} trim_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	setr_frame_if  frames_if();
	setr_result_if results_if();

	sliding_energy_silence_trim_core #(
		.WINDOW_MAX(WIN_MAX),
		.MAX_CHANNELS(2)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.frames(frames_if),
		.results(results_if)
	);

	// Shadow copy of the settings and the stream state of the trimmer.
	cfg_t             shadow_cfg;
	logic [31:0]      energy_hist [WIN_MAX];
	logic [SUM_W-1:0] energy_total;
	int unsigned      hist_slot;
	logic [IDX_W-1:0] frames_seen;
	logic             any_active;
	logic [IDX_W-1:0] first_loud;
	logic [IDX_W-1:0] last_loud;

	trim_result_t trim_results_due[$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int quiet_cycles;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_stream_state();
		for (int i = 0; i < WIN_MAX; i++) begin
			energy_hist[i] = '0;
		end
		energy_total = '0;
		hist_slot    = 0;
		frames_seen  = '0;
		any_active   = 1'b0;
		first_loud   = '0;
		last_loud    = '0;
	endfunction

	function automatic logic [31:0] sample_energy(logic [SAMPLE_W-1:0] s);
		logic [31:0] mag;
		mag = s[SAMPLE_W-1] ? (32'h10000 - {16'd0, s}) : {16'd0, s};
		return mag * mag;
	endfunction

	function automatic logic [IDX_W-1:0] sat_minus(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		return (a <= b) ? '0 : a - b;
	endfunction

	// Expected result word for one accepted frame; updates the shadow state.
	function automatic trim_result_t predict_trim(frame_t f);
		int unsigned      len;
		logic [31:0]      e;
		logic [31:0]      old;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] t;
		trim_result_t     r;
		len = shadow_cfg.window_len;
		if (len == 0) len = 1;
		if (len > WIN_MAX) len = WIN_MAX;
		if (hist_slot >= len) hist_slot = 0;

		e = sample_energy(f.left);
		if (shadow_cfg.channel_count != 2'd1) e = e + sample_energy(f.right);

		// Slide the window: drop the oldest energy, add the new one.
		old = energy_hist[hist_slot];
		energy_total = (energy_total >= SUM_W'(old)) ? energy_total - SUM_W'(old) : '0;
		energy_hist[hist_slot] = e;
		energy_total = energy_total + SUM_W'(e);

		idx = frames_seen;
		r = '0;
		r.active = (energy_total >= shadow_cfg.min_energy);
		if (r.active) begin
			if (!any_active) first_loud = idx;
			any_active = 1'b1;
			last_loud = idx;
		end
		hist_slot = (hist_slot + 1 >= len) ? 0 : hist_slot + 1;
		if (frames_seen != IDX_MAX) frames_seen = frames_seen + 1'b1;

		// The final frame carries the trim points and starts a fresh stream.
		r.done_res = f.last;
		if (f.last) begin
			r.found = any_active;
			r.frame_count = frames_seen;
			if (any_active) begin
				s = first_loud;
				t = last_loud;
				if (!shadow_cfg.clean_intro) begin
					s = '0;
				end else if (!shadow_cfg.clean_outro) begin
					t = sat_minus(t, IDX_W'(shadow_cfg.fade_len));
				end
				r.trim_start = sat_minus(s, IDX_W'(shadow_cfg.fade_len));
				r.trim_end = sat_minus(t, IDX_W'(shadow_cfg.fade_len));
			end
			clear_stream_state();
		end
		return r;
	endfunction

	// Register write; the shadow copy follows at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_WINDOW_LEN:    shadow_cfg.window_len = data[WLEN_W-1:0];
			REG_MIN_ENERGY:    shadow_cfg.min_energy = data[SUM_W-1:0];
			REG_FADE_LEN:      shadow_cfg.fade_len = data[FADE_W-1:0];
			REG_CLEAN_INTRO:   shadow_cfg.clean_intro = data[0];
			REG_CLEAN_OUTRO:   shadow_cfg.clean_outro = data[0];
			REG_CHANNEL_COUNT: shadow_cfg.channel_count = data[CH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_all(input int unsigned wl, input logic [CFG_DATA_W-1:0] thr,
		input int unsigned fade, input bit intro, input bit outro, input int unsigned ch);
		write_reg(REG_WINDOW_LEN, CFG_DATA_W'(wl));
		write_reg(REG_MIN_ENERGY, thr);
		write_reg(REG_FADE_LEN, CFG_DATA_W'(fade));
		write_reg(REG_CLEAN_INTRO, CFG_DATA_W'(intro));
		write_reg(REG_CLEAN_OUTRO, CFG_DATA_W'(outro));
		write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
	endtask

	// Offer one frame word, with random idle cycles ahead of it.
	task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
		input logic last);
		frame_t f;
		f.left = l;
		f.right = r;
		f.last = last;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			frames_if.valid <= 1'b0;
			@(negedge clk);
		end
		frames_if.valid <= 1'b1;
		frames_if.sample_left <= f.left;
		frames_if.sample_right <= f.right;
		frames_if.last_frame <= f.last;
		do @(posedge clk); while (!frames_if.ready);
		trim_results_due.push_back(predict_trim(f));
	endtask

	// Drop valid and let the pipeline empty out before touching settings.
	task automatic wait_idle();
		@(negedge clk);
		frames_if.valid <= 1'b0;
		while (trim_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Stream of quiet and loud stretches with some pure noise mixed in.
	task automatic send_random_stream(input int n);
		bit loud;
		logic [SAMPLE_W-1:0] l;
		logic [SAMPLE_W-1:0] r;
		loud = $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) loud = !loud;
			if (loud || $urandom_range(0, 9) == 0) begin
				l = SAMPLE_W'($urandom_range(0, 65535));
				r = SAMPLE_W'($urandom_range(0, 65535));
			end else begin
				l = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
				r = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
			end
			send_frame(l, r, i == n - 1);
		end
	endtask

	task automatic apply_random_settings();
		int unsigned           wl;
		int unsigned           eff;
		int unsigned           fade;
		int unsigned           pick;
		logic [CFG_DATA_W-1:0] thr;
		pick = $urandom_range(0, 9);
		case (pick)
			0: wl = 0;
			1: wl = 1023;
			2: wl = 512;
			3: wl = $urandom_range(0, 1023);
			default: wl = $urandom_range(1, 16);
		endcase
		eff = (wl == 0) ? 1 : ((wl > WIN_MAX) ? WIN_MAX : wl);

		// Threshold mostly scaled to the window so that trims land mid-stream.
		pick = $urandom_range(0, 19);
		if (pick == 0) thr = '0;
		else if (pick == 1) thr = '1;
		else if (pick == 2) thr = CFG_DATA_W'({$urandom, $urandom});
		else thr = CFG_DATA_W'(eff) * CFG_DATA_W'($urandom_range(1 << 12, 1 << 30));

		pick = $urandom_range(0, 9);
		if (pick == 0) fade = 0;
		else if (pick == 1) fade = 20'hFFFFF;
		else if (pick == 2) fade = $urandom_range(0, 20'hFFFFF);
		else fade = $urandom_range(0, 8);

		write_all(wl, thr, fade, $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 3));
	endtask

	// Settings out of reset, with a full-scale first frame.
	task automatic test_default_settings();
		send_frame(16'sh8000, 16'sh8000, 1'b0);
		send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b1);
		wait_idle();
	endtask

	// Mono window of four, pulled-back end, then a stream that never reaches the threshold.
	task automatic test_trim_edges();
		write_all(4, 41'd1000000000, 2, 1'b1, 1'b0, 1);
		send_frame(16'sh0000, 16'sh7FFF, 1'b0);
		send_frame(16'sh0001, 16'sh8000, 1'b0);
		send_frame(16'shFFFF, 16'sh0000, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b0);
		send_frame(16'sh8000, 16'sh0005, 1'b0);
		send_frame(16'sh7FFF, 16'shFFFF, 1'b0);
		send_frame(16'sh8000, 16'sh1234, 1'b0);
		send_frame(16'sh0002, 16'sh0000, 1'b0);
		send_frame(16'sh0000, 16'sh7FFF, 1'b0);
		send_frame(16'shFFFE, 16'sh8000, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b0);
		send_frame(16'sh0003, 16'sh0003, 1'b1);
		wait_idle();
		write_reg(REG_MIN_ENERGY, '1);
		send_frame(16'sh8000, 16'sh8000, 1'b1);
		wait_idle();
	endtask

	// Window shortened while a stream is open; zero threshold makes frame zero active.
	task automatic test_window_change();
		write_all(8, '0, 0, 1'b0, 1'b1, 3);
		for (int i = 0; i < 5; i++) begin
			send_frame(SAMPLE_W'(i * 1000), SAMPLE_W'(-i * 700), 1'b0);
		end
		wait_idle();
		write_reg(REG_WINDOW_LEN, CFG_DATA_W'(3));
		for (int i = 0; i < 4; i++) begin
			send_frame(SAMPLE_W'(i * 77), SAMPLE_W'(i * 99), i == 3);
		end
		wait_idle();
	endtask

	// Oversized window setting, which saturates to the ring depth.
	task automatic test_full_window();
		write_all(1023, CFG_DATA_W'(16) * CFG_DATA_W'(1 << 28), 100, 1'b1, 1'b1, 2);
		send_random_stream(40);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		int sent;
		int len;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < 4; k++) begin
			apply_random_settings();
			sent = 0;
			while (sent < n / 4) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
				send_random_stream(len);
				sent += len;
			end
			wait_idle();
		end
	endtask

	// Result side ready, stalling at the current rate.
	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		trim_result_t exp_res;
		trim_result_t got;
		if (arst_n && results_if.valid && results_if.ready) begin
			got.active = results_if.active;
			got.done_res = results_if.done_res;
			got.found = results_if.found;
			got.trim_start = results_if.trim_start;
			got.trim_end = results_if.trim_end;
			got.frame_count = results_if.frame_count;
			if (trim_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: active=%0d done=%0d", got.active, got.done_res);
			end else begin
				exp_res = trim_results_due.pop_front();
				if (got.active !== exp_res.active || got.done_res !== exp_res.done_res ||
					got.found !== exp_res.found || got.trim_start !== exp_res.trim_start ||
					got.trim_end !== exp_res.trim_end ||
					got.frame_count !== exp_res.frame_count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected act=%0d done=%0d found=%0d start=%0d end=%0d count=%0d",
							exp_res.active, exp_res.done_res, exp_res.found,
							exp_res.trim_start, exp_res.trim_end, exp_res.frame_count);
						$display("          actual   act=%0d done=%0d found=%0d start=%0d end=%0d count=%0d",
							got.active, got.done_res, got.found,
							got.trim_start, got.trim_end, got.frame_count);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("sliding_energy_silence_trim_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		frames_if.valid = 1'b0;
		frames_if.sample_left = '0;
		frames_if.sample_right = '0;
		frames_if.last_frame = 1'b0;
		results_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		shadow_cfg.window_len = RST_WINDOW_LEN;
		shadow_cfg.min_energy = RST_MIN_ENERGY;
		shadow_cfg.fade_len = RST_FADE_LEN;
		shadow_cfg.clean_intro = 1'b1;
		shadow_cfg.clean_outro = 1'b1;
		shadow_cfg.channel_count = RST_CHANNEL_COUNT;
		clear_stream_state();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_settings();
		test_trim_edges();
		test_window_change();
		test_full_window();
		test_random_traffic(0, 0, 64);
		test_random_traffic(64, 0, 64);
		test_random_traffic(0, 64, 64);
		test_random_traffic(36, 36, 64);

		wait_idle();
		if (mismatch_count == 0 && trim_results_due.size() == 0) begin
			$display("sliding_energy_silence_trim_core verification clean");
		end else begin
			$display("sliding_energy_silence_trim_core verification failed");
		end
		$finish;
	end

endmodule
